// ===== hdl/sha1_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 digest unit package
// Shared types, round constants and the command and status structures that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package sha1_pkg;

    typedef logic [31:0] t_word;

    localparam int unsigned WORD_W       = 32;
    localparam int unsigned BLOCK_BYTES  = 64;
    localparam int unsigned BLOCK_BITS   = BLOCK_BYTES * 8;
    localparam int unsigned POS_W        = $clog2(BLOCK_BYTES);
    localparam int unsigned ROUNDS       = 80;
    localparam int unsigned ROUND_W      = $clog2(ROUNDS);
    localparam int unsigned DIGEST_WORDS = 5;
    localparam int unsigned IDX_W        = 3;
    localparam int unsigned TOTAL_W      = 64;

    // Last byte position of a block, and the first position of the length field.
    localparam logic [POS_W-1:0]   POS_LAST    = POS_W'(BLOCK_BYTES - 1);
    localparam logic [POS_W-1:0]   POS_LEN     = POS_W'(BLOCK_BYTES - 8);
    localparam logic [ROUND_W-1:0] ROUND_LAST  = ROUND_W'(ROUNDS - 1);
    localparam logic [ROUND_W-1:0] ROUND_PH1   = ROUND_W'(20);
    localparam logic [ROUND_W-1:0] ROUND_PH2   = ROUND_W'(40);
    localparam logic [ROUND_W-1:0] ROUND_PH3   = ROUND_W'(60);
    localparam logic [IDX_W-1:0]   IDX_LAST    = IDX_W'(DIGEST_WORDS - 1);
    localparam logic [7:0]         PAD_MARK    = 8'h80;

    localparam t_word K_CH   = 32'h5a827999;
    localparam t_word K_PAR1 = 32'h6ed9eba1;
    localparam t_word K_MAJ  = 32'h8f1bbcdc;
    localparam t_word K_PAR2 = 32'hca62c1d6;

    localparam t_word H_INIT [DIGEST_WORDS] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        SEL_MSG,
        SEL_MARK,
        SEL_ZERO,
        SEL_LEN
    } t_byte_sel;

    typedef enum logic [1:0] {
        PH_CH,
        PH_PAR1,
        PH_MAJ,
        PH_PAR2
    } t_phase;

    typedef struct packed {
        logic             shift_byte;
        t_byte_sel        byte_sel;
        logic             count_byte;
        logic             round_en;
        logic             round_first;
        t_phase           phase;
        logic             add_en;
        logic             restart;
        logic [IDX_W-1:0] word_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic [POS_W-1:0] pos;
    } t_dp_status;

    function automatic t_word rotl(input t_word x, input int unsigned n);
        rotl = (x << n) | (x >> (WORD_W - n));
    endfunction

endpackage

// ===== hdl/sha1_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 controller
// Sequences byte intake, padding, the 80 rounds, the chaining add and the
// five-word digest output.
// ----------------------------------------------------------------------------
module sha1_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_byte_present,
    input  logic                           i_end_of_message,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [sha1_pkg::IDX_W-1:0]     o_word_index,
    output logic                           o_last_word,
    output sha1_pkg::t_dp_cmd              o_cmd,
    input  sha1_pkg::t_dp_status           i_status
);
    import sha1_pkg::*;

    t_state             r_state, n_state;
    logic [ROUND_W-1:0] r_round, n_round;
    logic [IDX_W-1:0]   r_oidx, n_oidx;
    logic               r_closing, n_closing;
    logic               r_mark, n_mark;
    logic               r_len_blk, n_len_blk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_round   <= '0;
            r_oidx    <= '0;
            r_closing <= 1'b0;
            r_mark    <= 1'b0;
            r_len_blk <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_round   <= n_round;
            r_oidx    <= n_oidx;
            r_closing <= n_closing;
            r_mark    <= n_mark;
            r_len_blk <= n_len_blk;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_round   = r_round;
        n_oidx    = r_oidx;
        n_closing = r_closing;
        n_mark    = r_mark;
        n_len_blk = r_len_blk;
        o_cmd     = '0;
        o_cmd.byte_sel = SEL_MSG;
        o_cmd.phase    = PH_CH;
        o_cmd.word_idx = r_oidx;
        o_stall   = 1'b1;
        o_valid   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    n_closing = i_end_of_message;
                    n_mark    = 1'b0;
                    n_len_blk = 1'b0;
                    if (i_byte_present) begin
                        o_cmd.shift_byte = 1'b1;
                        o_cmd.count_byte = 1'b1;
                        if (i_status.pos == POS_LAST) begin
                            n_state = ST_ROUND;
                        end else if (i_end_of_message) begin
                            n_state = ST_PAD;
                        end
                    end else if (i_end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end

            ST_ROUND: begin
                o_cmd.round_en    = 1'b1;
                o_cmd.round_first = (r_round == '0);
                if (r_round < ROUND_PH1) begin
                    o_cmd.phase = PH_CH;
                end else if (r_round < ROUND_PH2) begin
                    o_cmd.phase = PH_PAR1;
                end else if (r_round < ROUND_PH3) begin
                    o_cmd.phase = PH_MAJ;
                end else begin
                    o_cmd.phase = PH_PAR2;
                end
                if (r_round == ROUND_LAST) begin
                    n_round = '0;
                    n_state = ST_ADD;
                end else begin
                    n_round = r_round + 1'b1;
                end
            end

            ST_ADD: begin
                o_cmd.add_en = 1'b1;
                if (!r_closing) begin
                    n_state = ST_IDLE;
                end else if (r_len_blk) begin
                    n_oidx  = '0;
                    n_state = ST_OUT;
                end else begin
                    n_len_blk = 1'b1;
                    n_state   = ST_PAD;
                end
            end

            ST_PAD: begin
                o_cmd.shift_byte = 1'b1;
                if (!r_mark) begin
                    o_cmd.byte_sel = SEL_MARK;
                    n_mark = 1'b1;
                    if (i_status.pos < POS_LEN) begin
                        n_len_blk = 1'b1;
                    end
                end else if (r_len_blk && (i_status.pos >= POS_LEN)) begin
                    o_cmd.byte_sel = SEL_LEN;
                end else begin
                    o_cmd.byte_sel = SEL_ZERO;
                end
                if (i_status.pos == POS_LAST) begin
                    n_state = ST_ROUND;
                end
            end

            ST_OUT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    if (r_oidx == IDX_LAST) begin
                        o_cmd.restart = 1'b1;
                        n_closing     = 1'b0;
                        n_oidx        = '0;
                        n_state       = ST_IDLE;
                    end else begin
                        n_oidx = r_oidx + 1'b1;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_word_index = r_oidx;
    assign o_last_word  = (r_oidx == IDX_LAST);

endmodule

// ===== hdl/sha1_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 datapath
// Block shift register that doubles as the message schedule window, the
// round logic, the chaining words and the 64-bit byte count.
// ----------------------------------------------------------------------------
module sha1_dpath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0]           i_msg_byte,
    input  sha1_pkg::t_dp_cmd    i_cmd,
    output sha1_pkg::t_dp_status o_status,
    output sha1_pkg::t_word      o_digest_word
);
    import sha1_pkg::*;

    logic [BLOCK_BITS-1:0] r_buf;
    t_word                 r_work [DIGEST_WORDS];
    t_word                 r_chain [DIGEST_WORDS];
    logic [TOTAL_W-1:0]    r_total;
    logic [POS_W-1:0]      r_pos;

    logic [TOTAL_W-1:0]    bit_len;
    logic [POS_W-1:0]      len_hi;
    logic [7:0]            pad_byte;
    t_word                 w_cur, w_new;
    t_word                 sa, sb, sc, sd, se;
    t_word                 f_val, k_val, t_val;

    // Word k of the window sits k words below the top of the buffer.
    assign w_cur = r_buf[BLOCK_BITS-1 -: WORD_W];
    assign w_new = rotl(r_buf[BLOCK_BITS-1-13*WORD_W -: WORD_W]
                      ^ r_buf[BLOCK_BITS-1-8*WORD_W -: WORD_W]
                      ^ r_buf[BLOCK_BITS-1-2*WORD_W -: WORD_W]
                      ^ w_cur, 1);

    // The length goes out most significant byte first over the last eight slots.
    assign bit_len = {r_total[TOTAL_W-4:0], 3'b000};
    assign len_hi  = {~r_pos[2:0], 3'b111};

    always_comb begin
        case (i_cmd.byte_sel)
            SEL_MSG:  pad_byte = i_msg_byte;
            SEL_MARK: pad_byte = PAD_MARK;
            SEL_LEN:  pad_byte = bit_len[len_hi -: 8];
            default:  pad_byte = 8'h00;
        endcase
    end

    always_comb begin
        if (i_cmd.round_first) begin
            sa = r_chain[0];
            sb = r_chain[1];
            sc = r_chain[2];
            sd = r_chain[3];
            se = r_chain[4];
        end else begin
            sa = r_work[0];
            sb = r_work[1];
            sc = r_work[2];
            sd = r_work[3];
            se = r_work[4];
        end
        case (i_cmd.phase)
            PH_CH: begin
                f_val = (sb & sc) | (~sb & sd);
                k_val = K_CH;
            end
            PH_PAR1: begin
                f_val = sb ^ sc ^ sd;
                k_val = K_PAR1;
            end
            PH_MAJ: begin
                f_val = (sb & sc) | (sb & sd) | (sc & sd);
                k_val = K_MAJ;
            end
            default: begin
                f_val = sb ^ sc ^ sd;
                k_val = K_PAR2;
            end
        endcase
        t_val = rotl(sa, 5) + f_val + se + k_val + w_cur;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_byte) begin
            r_buf <= {r_buf[BLOCK_BITS-9:0], pad_byte};
        end else if (i_cmd.round_en) begin
            r_buf <= {r_buf[BLOCK_BITS-WORD_W-1:0], w_new};
        end
        if (i_cmd.round_en) begin
            r_work[0] <= t_val;
            r_work[1] <= sa;
            r_work[2] <= rotl(sb, 30);
            r_work[3] <= sc;
            r_work[4] <= sd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                r_chain[i] <= H_INIT[i];
            end
            r_total <= '0;
            r_pos   <= '0;
        end else begin
            if (i_cmd.add_en) begin
                for (int i = 0; i < DIGEST_WORDS; i++) begin
                    r_chain[i] <= r_chain[i] + r_work[i];
                end
            end
            if (i_cmd.count_byte) begin
                r_total <= r_total + 1'b1;
            end
            if (i_cmd.shift_byte) begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    assign o_status.pos  = r_pos;
    assign o_digest_word = r_chain[i_cmd.word_idx];

endmodule

// ===== hdl/sha1_message_digest_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 message digest unit
// Takes a message one byte per item, compresses each 64-byte block, pads the
// message on its end and returns the 160-bit digest as five 32-bit items.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake           Payload
//  -------  ------------------  ---------------------------------------------
//  in       i_valid / o_stall   i_msg_byte, i_byte_present, i_end_of_message
//  out      o_valid / i_stall   o_digest_word, o_word_index, o_last_word
//
// A byte that does not complete a block is taken without a stall. The byte that
// completes a block holds o_stall high through the 80 rounds, one per cycle, and the add.
// A closing item pads one byte per cycle to the end of the block, compresses once
// or twice, then offers five digest words, one per cycle while i_stall is low.
// Reset is synchronous and active low; it loads the chaining values, clears the count.
// ----------------------------------------------------------------------------
module sha1_message_digest_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [7:0]                 i_msg_byte,
    input  logic                       i_byte_present,
    input  logic                       i_end_of_message,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [31:0]                o_digest_word,
    output logic [sha1_pkg::IDX_W-1:0] o_word_index,
    output logic                       o_last_word
);
    import sha1_pkg::*;

    // The controller owns all sequencing; the datapath only follows commands
    // and reports its fill position within the current block.
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    sha1_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_byte_present   (i_byte_present),
        .i_end_of_message (i_end_of_message),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word),
        .o_cmd            (dp_cmd),
        .i_status         (dp_status)
    );

    // The buffer shifts in message and padding bytes, then serves as the
    // sliding 16-word schedule window while the rounds run.
    sha1_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_msg_byte    (i_msg_byte),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .o_digest_word (o_digest_word)
    );

endmodule

// ===== dv/sha1_message_digest_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 message digest unit testbench
// Streams messages into the unit one byte per item, computes the expected
// digest words alongside and checks every returned word in order, with random
// idle bursts on both channels and one long hold on the digest side.
// ----------------------------------------------------------------------------
module sha1_message_digest_unit_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int ITEM_TARGET  = 320;
    localparam int QUIET_AFTER  = 270;
    localparam int HOLD_AT      = 120;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        sha1_pkg::t_word            word;
        logic [sha1_pkg::IDX_W-1:0] idx;
        logic                       last;
    } t_digest_word;

    // Running SHA-1 of the current message and the digest words still owed.
    class t_digest_tracker;
        logic [31:0]  chain [5];
        logic [7:0]   blk [64];
        logic [63:0]  nbytes;
        t_digest_word pending [$];
        int unsigned  mismatches;

        function new();
            foreach (blk[i]) blk[i] = 8'h00;
            restart();
        endfunction

        function void restart();
            chain[0] = 32'h67452301;
            chain[1] = 32'hefcdab89;
            chain[2] = 32'h98badcfe;
            chain[3] = 32'h10325476;
            chain[4] = 32'hc3d2e1f0;
            nbytes   = '0;
        endfunction

        function logic [31:0] rol(logic [31:0] x, int n);
            logic [63:0] twice;
            twice = {x, x};
            return twice[63-n -: 32];
        endfunction

        function void compress();
            logic [31:0] w [80];
            logic [31:0] a, b, c, d, e, f, k, t;
            for (int i = 0; i < 16; i++)
                w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            for (int i = 16; i < 80; i++)
                w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            e = chain[4];
            for (int i = 0; i < 80; i++) begin
                if (i < 20) begin
                    f = (b & c) | (~b & d);
                    k = sha1_pkg::K_CH;
                end else if (i < 40) begin
                    f = b ^ c ^ d;
                    k = sha1_pkg::K_PAR1;
                end else if (i < 60) begin
                    f = (b & c) | (b & d) | (c & d);
                    k = sha1_pkg::K_MAJ;
                end else begin
                    f = b ^ c ^ d;
                    k = sha1_pkg::K_PAR2;
                end
                t = rol(a, 5) + f + e + k + w[i];
                e = d;
                d = c;
                c = rol(b, 30);
                b = a;
                a = t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
            chain[4] += e;
        endfunction

        // Called for every accepted input item.
        function void take_item(logic [7:0] data, logic present, logic eom);
            int           pos;
            logic [63:0]  bits;
            t_digest_word dw;
            if (present) begin
                pos = int'(nbytes[5:0]);
                blk[pos] = data;
                nbytes++;
                if (pos == 63)
                    compress();
            end
            if (!eom)
                return;
            // Pad mark, zero fill, then the bit length; a second block is
            // needed when the length field no longer fits behind the mark.
            pos = int'(nbytes[5:0]);
            blk[pos] = 8'h80;
            pos++;
            if (pos > 56) begin
                while (pos < 64) begin
                    blk[pos] = 8'h00;
                    pos++;
                end
                compress();
                pos = 0;
            end
            while (pos < 56) begin
                blk[pos] = 8'h00;
                pos++;
            end
            bits = nbytes << 3;
            for (int i = 0; i < 8; i++)
                blk[56+i] = bits[63-8*i -: 8];
            compress();
            for (int i = 0; i < 5; i++) begin
                dw.word = chain[i];
                dw.idx  = i[sha1_pkg::IDX_W-1:0];
                dw.last = (i == 4);
                pending.push_back(dw);
            end
            restart();
        endfunction

        function void note_mismatch(string text);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] digest mismatch: %s", $realtime, text);
        endfunction

        // Called for every accepted digest word.
        function void match_word(sha1_pkg::t_word word, logic [sha1_pkg::IDX_W-1:0] idx,
                                 logic last);
            t_digest_word want;
            if (pending.size() == 0) begin
                note_mismatch($sformatf("unexpected word %08h index %0d last %0b",
                                        word, idx, last));
                return;
            end
            want = pending.pop_front();
            if (word !== want.word || idx !== want.idx || last !== want.last)
                note_mismatch($sformatf("expected %08h/%0d/%0b, got %08h/%0d/%0b",
                                        want.word, want.idx, want.last, word, idx, last));
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic [7:0]                 i_msg_byte;
    logic                       i_byte_present;
    logic                       i_end_of_message;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic [31:0]                o_digest_word;
    logic [sha1_pkg::IDX_W-1:0] o_word_index;
    logic                       o_last_word;

    t_digest_tracker sb = new();

    int unsigned cycle_count = 0;
    int unsigned items_taken = 0;
    bit          quiet       = 1'b0;
    bit          hold_armed  = 1'b0;
    bit          hold_done   = 1'b0;
    int          hold_left   = 0;
    int          burst_left  = 0;

    sha1_message_digest_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_msg_byte      (i_msg_byte),
        .i_byte_present  (i_byte_present),
        .i_end_of_message(i_end_of_message),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_digest_word   (o_digest_word),
        .o_word_index    (o_word_index),
        .o_last_word     (o_last_word)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Digest side: random stall bursts, plus one long hold so that the unit
    // backs up with a finished digest and has to stall its input.
    always @(negedge i_clk) begin
        if (hold_armed && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            i_stall = 1'b1;
            hold_left--;
        end else if (quiet) begin
            i_stall = 1'b0;
        end else begin
            if (burst_left == 0 && $urandom_range(0, 7) == 0)
                burst_left = $urandom_range(1, 11);
            if (burst_left > 0) begin
                i_stall = 1'b1;
                burst_left--;
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.match_word(o_digest_word, o_word_index, o_last_word);
    end

    // Entered and left at a falling edge; valid stays high on return so the
    // next item follows without a gap unless an idle burst is drawn.
    task automatic send_item(input logic [7:0] data, input logic present, input logic eom);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid          = 1'b1;
        i_msg_byte       = data;
        i_byte_present   = present;
        i_end_of_message = eom;
        do
            @(posedge i_clk);
        while (o_stall);
        sb.take_item(data, present, eom);
        if (present || eom)
            items_taken++;
        if (items_taken >= HOLD_AT)
            hold_armed = 1'b1;
        if (items_taken >= QUIET_AFTER)
            quiet = 1'b1;
        @(negedge i_clk);
    endtask

    // A message of random bytes with the odd ignored item mixed in; the end
    // either rides on the last byte or comes as an item of its own.
    task automatic send_message(input int len);
        bit merge_end;
        merge_end = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, merge_end && (i == len - 1));
        end
        if (!merge_end)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin
        int unsigned fixed_lens [3];
        int          len;
        fixed_lens = '{55, 56, 64};
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_msg_byte       = 8'h00;
        i_byte_present   = 1'b0;
        i_end_of_message = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: an ignored item, the empty message, a byte with the end
        // in one item, extreme byte values and the classic three-byte text.
        send_item(8'ha5, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h5a, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);

        // Lengths around the padding boundary first, then mostly short
        // messages with an occasional long one.
        foreach (fixed_lens[i])
            send_message(fixed_lens[i]);
        while (items_taken < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0:       len = $urandom_range(54, 66);
                1:       len = $urandom_range(118, 130);
                default: len = $urandom_range(0, 24);
            endcase
            send_message(len);
        end
        i_valid = 1'b0;

        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
